/* rtl/fwks_pkg.sv */
// shared constants, types and helpers for the order queue with key search
package fwks_pkg;

   localparam int DEPTH     = 16;
   localparam int DATA_BITS = 32;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int NUM_W     = 16;
   localparam int ODATA_W   = 32;
   localparam int REQ_W     = 2;
   localparam int STS_W     = 2;

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [NUM_W-1:0]     num_type;
   typedef logic [DATA_BITS-1:0] data_type;
   typedef logic [ODATA_W-1:0]   odata_type;

   typedef enum logic [REQ_W-1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_SRCH = 2'd2
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DEQ_WB,
      ST_SRCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      num_type  num;
      data_type data;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic enq;
      logic deq_rd;
      logic deq_done;
      logic srch_init;
      logic srch_step;
      logic load_rsp;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   srch_done;
   } dp_stat_type;

   function automatic idx_type next_idx(idx_type i);
      idx_type r;
      if (i == idx_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + idx_type'(1);
      end
      return r;
   endfunction

endpackage

/* rtl/fwks_if.sv */
// request and response channel interfaces
interface fwks_req_if;
   logic                          valid;
   logic                          ready;
   logic [fwks_pkg::REQ_W-1:0]    req_type;
   logic [fwks_pkg::NUM_W-1:0]    order_number;
   logic [fwks_pkg::ODATA_W-1:0]  order_data;

   modport source (output valid, output req_type, output order_number,
                   output order_data, input ready);
   modport sink   (input valid, input req_type, input order_number,
                   input order_data, output ready);
endinterface

interface fwks_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fwks_pkg::STS_W-1:0]    status;
   logic                          found;
   logic [fwks_pkg::NUM_W-1:0]    out_order_number;
   logic [fwks_pkg::ODATA_W-1:0]  out_order_data;
   logic                          queue_empty;

   modport source (output valid, output status, output found,
                   output out_order_number, output out_order_data,
                   output queue_empty, input ready);
   modport sink   (input valid, input status, input found,
                   input out_order_number, input out_order_data,
                   input queue_empty, output ready);
endinterface

/* rtl/fwks_ctrl.sv */
// sequencing state machine and response handshake
module fwks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  fwks_pkg::dp_stat_type  stat,
   output fwks_pkg::ctrl_cmd_type cmd
);

   fwks_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwks_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         fwks_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = fwks_pkg::ST_DECODE;
            end
         end
         fwks_pkg::ST_DECODE: begin
            unique case (stat.op)
               fwks_pkg::OP_ENQ: begin
                  cmd.enq  = 1'b1;
                  state_in = fwks_pkg::ST_FINISH;
               end
               fwks_pkg::OP_DEQ: begin
                  cmd.deq_rd = 1'b1;
                  state_in   = stat.empty ? fwks_pkg::ST_FINISH : fwks_pkg::ST_DEQ_WB;
               end
               fwks_pkg::OP_SRCH: begin
                  cmd.srch_init = 1'b1;
                  state_in      = fwks_pkg::ST_SRCH;
               end
               // unused request code: plain response
               default: state_in = fwks_pkg::ST_FINISH;
            endcase
         end
         fwks_pkg::ST_DEQ_WB: begin
            cmd.deq_done = 1'b1;
            state_in     = fwks_pkg::ST_FINISH;
         end
         fwks_pkg::ST_SRCH: begin
            cmd.srch_step = 1'b1;
            if (stat.srch_done) begin
               state_in = fwks_pkg::ST_FINISH;
            end
         end
         fwks_pkg::ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = fwks_pkg::ST_IDLE;
            end
         end
         default: state_in = fwks_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/fwks_dp.sv */
// entry memory, queue pointers, search walker and response register
module fwks_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  fwks_pkg::ctrl_cmd_type        cmd,
   output fwks_pkg::dp_stat_type         stat,
   input  logic [fwks_pkg::REQ_W-1:0]    req_type,
   input  logic [fwks_pkg::NUM_W-1:0]    order_number,
   input  logic [fwks_pkg::ODATA_W-1:0]  order_data,
   output logic [fwks_pkg::STS_W-1:0]    status,
   output logic                          found,
   output logic [fwks_pkg::NUM_W-1:0]    out_order_number,
   output logic [fwks_pkg::ODATA_W-1:0]  out_order_data,
   output logic                          queue_empty
);

   fwks_pkg::entry_type mem [fwks_pkg::DEPTH];
   fwks_pkg::entry_type rd_ff;
   fwks_pkg::idx_type   rd_addr;
   logic                mem_we;

   fwks_pkg::idx_type    head_ff, head_in, tail_ff, tail_in, ptr_ff, ptr_in;
   fwks_pkg::cnt_type    count_ff, count_in, left_ff, left_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   fwks_pkg::op_type     op_ff, op_in;
   fwks_pkg::num_type    key_ff, key_in;
   fwks_pkg::data_type   wdata_ff, wdata_in;
   fwks_pkg::status_type sts_ff, sts_in;
   logic                 hit_ff, hit_in;
   fwks_pkg::num_type    onum_ff, onum_in;
   fwks_pkg::odata_type  odata_ff, odata_in;

   logic [fwks_pkg::STS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                         rsp_found_ff, rsp_found_in;
   fwks_pkg::num_type            rsp_num_ff, rsp_num_in;
   fwks_pkg::odata_type          rsp_data_ff, rsp_data_in;
   logic                         rsp_empty_ff, rsp_empty_in;

   logic full, empty;

   assign full  = (count_ff == fwks_pkg::cnt_type'(fwks_pkg::DEPTH));
   assign empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      wdata_ff      <= wdata_in;
      sts_ff        <= sts_in;
      hit_ff        <= hit_in;
      onum_ff       <= onum_in;
      odata_ff      <= odata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // single write port at the tail, single registered read port
   assign rd_addr = cmd.srch_step ? ptr_ff : head_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= '{num: key_ff, data: wdata_ff};
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      cmp_valid_in  = 1'b0;
      op_in         = op_ff;
      key_in        = key_ff;
      wdata_in      = wdata_ff;
      sts_in        = sts_ff;
      hit_in        = hit_ff;
      onum_in       = onum_ff;
      odata_in      = odata_ff;
      mem_we        = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (cmd.latch_req) begin
         op_in    = fwks_pkg::op_type'(req_type);
         key_in   = order_number;
         wdata_in = fwks_pkg::data_type'(order_data);
         sts_in   = fwks_pkg::STS_OK;
         hit_in   = 1'b0;
         onum_in  = '0;
         odata_in = '0;
      end

      if (cmd.enq) begin
         if (full) begin
            sts_in = fwks_pkg::STS_FULL;
         end else begin
            mem_we   = 1'b1;
            tail_in  = fwks_pkg::next_idx(tail_ff);
            count_in = count_ff + fwks_pkg::cnt_type'(1);
         end
      end

      if (cmd.deq_rd && empty) begin
         sts_in = fwks_pkg::STS_EMPTY;
      end

      if (cmd.deq_done) begin
         onum_in  = rd_ff.num;
         odata_in = fwks_pkg::odata_type'(rd_ff.data);
         head_in  = fwks_pkg::next_idx(head_ff);
         count_in = count_ff - fwks_pkg::cnt_type'(1);
      end

      if (cmd.srch_init) begin
         ptr_in  = head_ff;
         left_in = count_ff;
      end

      // read one entry per cycle, compare it the cycle after
      if (cmd.srch_step && (left_ff != '0)) begin
         cmp_valid_in = 1'b1;
         ptr_in       = fwks_pkg::next_idx(ptr_ff);
         left_in      = left_ff - fwks_pkg::cnt_type'(1);
      end

      if (cmp_valid_ff && (rd_ff.num == key_ff)) begin
         hit_in = 1'b1;
      end

      if (cmd.load_rsp) begin
         rsp_status_in = sts_ff;
         rsp_found_in  = hit_ff;
         rsp_num_in    = onum_ff;
         rsp_data_in   = odata_ff;
         rsp_empty_in  = empty;
      end
   end

   assign stat.op        = op_ff;
   assign stat.full      = full;
   assign stat.empty     = empty;
   assign stat.srch_done = (left_ff == '0) && !cmp_valid_ff;

   assign status           = rsp_status_ff;
   assign found            = rsp_found_ff;
   assign out_order_number = rsp_num_ff;
   assign out_order_data   = rsp_data_ff;
   assign queue_empty      = rsp_empty_ff;

endmodule

/* rtl/fifo_with_key_search_top.sv */
// top level of the order queue with key search
//
//   channel   role     handshake          payload
//   req_chan  input    valid/ready        req_type, order_number, order_data
//   rsp_chan  output   valid/ready        status, found, out_order_number,
//                                         out_order_data, queue_empty
//
// one item at a time; the entry memory has a single read port, so a search walks the
// queue one entry a cycle from the head, and each read is registered before its compare.
// synchronous reset clears pointers and count; the entry memory is not cleared.
// a waiting result sits in the output register while the next item is taken;
// the block only holds off at the end of that item until the result is taken.
module fifo_with_key_search_top (
   input  logic         clock,
   input  logic         reset,
   fwks_req_if.sink     req_chan,
   fwks_rsp_if.source   rsp_chan
);

   fwks_pkg::ctrl_cmd_type cmd;
   fwks_pkg::dp_stat_type  stat;

   fwks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fwks_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_chan.req_type),
      .order_number     (req_chan.order_number),
      .order_data       (req_chan.order_data),
      .status           (rsp_chan.status),
      .found            (rsp_chan.found),
      .out_order_number (rsp_chan.out_order_number),
      .out_order_data   (rsp_chan.out_order_data),
      .queue_empty      (rsp_chan.queue_empty)
   );

endmodule
